@@ rtl/gbpe_pkg.sv @@
`default_nettype none

package gbpe_pkg;

  localparam int unsigned ByteBits    = 8;
  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned SlotBits    = 4;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned AddrBits    = 5;

  localparam logic [SlotBits-1:0] SlotsOneBit = SlotBits'(8);
  localparam logic [SlotBits-1:0] SlotsTwoBit = SlotBits'(4);
  localparam logic [1:0]          LevelMask   = 2'h3;
  localparam logic [1:0]          LevelOne    = 2'd1;

  typedef enum logic [2:0] {
    RegCursorX    = 3'd0,
    RegCursorY    = 3'd1,
    RegBearLeft   = 3'd2,
    RegBearTop    = 3'd3,
    RegWidth      = 3'd4,
    RegHeight     = 3'd5,
    RegTwoBit     = 3'd6,
    RegDrawBlack  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] bitmap_byte;
    logic       glyph_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               pixel_color;
    logic               last_of_byte;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic signed [7:0]  bearing_left;
    logic signed [7:0]  bearing_top;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic               two_bit_mode;
    logic               draw_black;
  } cfg_t;

  typedef struct packed {
    logic [ByteBits-1:0] mask;
    logic [SlotBits-1:0] slots;
    logic                start;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/gbpe_cfg.sv @@
`default_nettype none

module gbpe_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbpe_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output gbpe_pkg::cfg_t                     cfg_o
);

  localparam gbpe_pkg::cfg_t CfgReset = '{draw_black: 1'b1, default: '0};

  gbpe_pkg::cfg_t     cfg_q, cfg_d;
  gbpe_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = gbpe_pkg::reg_idx_e'(paddr[gbpe_pkg::AddrBits-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        gbpe_pkg::RegCursorX:   cfg_d.pen_x        = pwdata[15:0];
        gbpe_pkg::RegCursorY:   cfg_d.pen_y        = pwdata[15:0];
        gbpe_pkg::RegBearLeft:  cfg_d.bearing_left = pwdata[7:0];
        gbpe_pkg::RegBearTop:   cfg_d.bearing_top  = pwdata[7:0];
        gbpe_pkg::RegWidth:     cfg_d.glyph_width  = pwdata[7:0];
        gbpe_pkg::RegHeight:    cfg_d.glyph_height = pwdata[7:0];
        gbpe_pkg::RegTwoBit:    cfg_d.two_bit_mode = pwdata[0];
        gbpe_pkg::RegDrawBlack: cfg_d.draw_black   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      gbpe_pkg::RegCursorX:   prdata = {16'd0, cfg_q.pen_x};
      gbpe_pkg::RegCursorY:   prdata = {16'd0, cfg_q.pen_y};
      gbpe_pkg::RegBearLeft:  prdata = {24'd0, cfg_q.bearing_left};
      gbpe_pkg::RegBearTop:   prdata = {24'd0, cfg_q.bearing_top};
      gbpe_pkg::RegWidth:     prdata = {24'd0, cfg_q.glyph_width};
      gbpe_pkg::RegHeight:    prdata = {24'd0, cfg_q.glyph_height};
      gbpe_pkg::RegTwoBit:    prdata = {31'd0, cfg_q.two_bit_mode};
      gbpe_pkg::RegDrawBlack: prdata = {31'd0, cfg_q.draw_black};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbpe_front.sv @@
`default_nettype none

module gbpe_front (
  input  wire logic               in_valid_i,
  input  gbpe_pkg::in_item_t      in_item_i,
  output logic                    in_stall_o,
  input  wire logic               two_bit_i,
  input  wire logic               black_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output gbpe_pkg::job_t          q_job_o
);

  logic [7:0] byte_v;
  logic [7:0] mask_two;
  logic [1:0] lvl;

  assign byte_v     = in_item_i.bitmap_byte;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // classify each 2-bit level: black draws 2 and 3, white draws only 1
  always_comb begin
    mask_two = '0;
    lvl      = '0;
    for (int i = 0; i < 4; i++) begin
      lvl = 2'(byte_v >> (6 - 2 * i)) & gbpe_pkg::LevelMask;
      mask_two[7-i] = black_i ? lvl[1] : (lvl == gbpe_pkg::LevelOne);
    end
  end

  always_comb begin
    q_job_o.start = in_item_i.glyph_start;
    if (two_bit_i) begin
      q_job_o.mask  = mask_two;
      q_job_o.slots = gbpe_pkg::SlotsTwoBit;
    end else begin
      q_job_o.mask  = byte_v;
      q_job_o.slots = gbpe_pkg::SlotsOneBit;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbpe_queue.sv @@
`default_nettype none

module gbpe_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  gbpe_pkg::job_t job_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output gbpe_pkg::job_t job_o
);

  localparam int unsigned PtrBits = $clog2(gbpe_pkg::QueueDepth);
  localparam int unsigned CntBits = $clog2(gbpe_pkg::QueueDepth + 1);

  gbpe_pkg::job_t     mem_q [gbpe_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(gbpe_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(gbpe_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(gbpe_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gbpe_back.sv @@
`default_nettype none

module gbpe_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  gbpe_pkg::cfg_t     cfg_i,
  input  wire logic          job_valid_i,
  input  gbpe_pkg::job_t     job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gbpe_pkg::out_item_t out_item_o
);

  localparam int unsigned MaskBits =
    (COORD_BITS < gbpe_pkg::CoordWidth) ? COORD_BITS : gbpe_pkg::CoordWidth;
  localparam logic [15:0] CoordMask = 16'((33'd1 << MaskBits) - 33'd1);

  logic                                active_q, active_d;
  logic [7:0]                          mask_q, mask_d;
  logic [gbpe_pkg::SlotBits-1:0]       left_q, left_d;
  logic [7:0]                          row_q, row_d, col_q, col_d;
  logic                                fin_q, fin_d;
  logic                                pend_vld_q, pend_vld_d;
  gbpe_pkg::out_item_t                 pend_q, pend_d;
  logic                                out_vld_q, out_vld_d;
  gbpe_pkg::out_item_t                 out_q, out_d;

  logic [7:0]  w, h, row_inc;
  logic [15:0] base_x, base_y, pix_x, pix_y;
  logic        out_free, halt, draw, step, wrap, fin_adv, ends;
  logic        push_step, flush, out_load;

  assign w        = cfg_i.glyph_width;
  assign h        = cfg_i.glyph_height;
  assign base_x   = cfg_i.pen_x + {{8{cfg_i.bearing_left[7]}}, cfg_i.bearing_left};
  assign base_y   = cfg_i.pen_y - {{8{cfg_i.bearing_top[7]}}, cfg_i.bearing_top};
  assign pix_x    = (base_x + {8'd0, col_q}) & CoordMask;
  assign pix_y    = (base_y + {8'd0, row_q}) & CoordMask;

  assign out_free = !out_vld_q || !out_stall_i;
  assign halt     = fin_q || (w == 8'd0) || (h == 8'd0) || (row_q >= h);
  assign draw     = mask_q[7];
  assign step     = active_q && (halt || !draw || !pend_vld_q || out_free);
  assign wrap     = ({1'b0, col_q} + 9'd1) >= {1'b0, w};
  assign row_inc  = row_q + 8'd1;
  assign fin_adv  = wrap && ((row_inc == 8'd0) || (row_inc >= h));
  assign ends     = halt || (left_q == gbpe_pkg::SlotBits'(1)) || fin_adv;

  assign push_step = step && !halt && draw && pend_vld_q;
  assign flush     = !push_step && pend_vld_q && pend_q.last_of_byte && out_free;
  assign out_load  = push_step || flush;

  assign job_pop_o   = job_valid_i && (!active_q || (step && ends));
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_comb begin
    active_d   = active_q;
    mask_d     = mask_q;
    left_d     = left_q;
    row_d      = row_q;
    col_d      = col_q;
    fin_d      = fin_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;

    if (out_load) begin
      out_d     = pend_q;
      out_vld_d = 1'b1;
      pend_vld_d = 1'b0;
    end

    if (step) begin
      mask_d = {mask_q[6:0], 1'b0};
      left_d = left_q - 1'b1;
      if (halt) begin
        fin_d = 1'b1;
      end else begin
        if (wrap) begin
          col_d = '0;
          row_d = row_inc;
        end else begin
          col_d = col_q + 8'd1;
        end
        if (fin_adv) begin
          fin_d = 1'b1;
        end
      end
      if (!halt && draw) begin
        pend_vld_d          = 1'b1;
        pend_d.pixel_x      = pix_x;
        pend_d.pixel_y      = pix_y;
        pend_d.pixel_color  = cfg_i.draw_black;
        pend_d.last_of_byte = ends;
      end else if (ends && pend_vld_q) begin
        pend_d.last_of_byte = 1'b1;
      end
      if (ends) begin
        active_d = 1'b0;
      end
    end

    if (job_pop_o) begin
      active_d = 1'b1;
      mask_d   = job_i.mask;
      left_d   = job_i.slots;
      if (job_i.start) begin
        row_d = '0;
        col_d = '0;
        fin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    left_q <= left_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      fin_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      active_q   <= active_d;
      row_q      <= row_d;
      col_q      <= col_d;
      fin_q      <= fin_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/glyph_bitmap_pixel_expander.sv @@
// Path: an accepted byte passes the queue to the pixel unit; a drawn pixel waits in the pending
// register until the byte's next drawn pixel or its end settles last_of_byte, then in the output.
// Throughput: while the output is not stalled, one slot and at most one pixel per cycle; a byte
// covers up to 8 slots in 1-bit mode, 4 in 2-bit mode, 1 once the glyph is finished.
// Reset: registers take their defaults (draw_black set), counters clear as at a glyph
// start, queue and output empty; no clearing pass.
`default_nettype none

module glyph_bitmap_pixel_expander #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  gbpe_pkg::in_item_t                 in_item_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output gbpe_pkg::out_item_t                out_item_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbpe_pkg::AddrBits-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  gbpe_pkg::cfg_t cfg;
  gbpe_pkg::job_t push_job, pop_job;
  logic           q_full, q_push, q_valid, q_pop;

  gbpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gbpe_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .two_bit_i  (cfg.two_bit_mode),
    .black_i    (cfg.draw_black),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  gbpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  gbpe_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_glyph_bitmap_pixel_expander.sv @@
`default_nettype none

module tb_glyph_bitmap_pixel_expander;
  import gbpe_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int SettleCycles = 40;
  localparam int RandomItems  = 385;

  typedef struct {
    bit               is_write;
    reg_idx_e         idx;
    logic [31:0]      val;
    in_item_t         it;
    int               n_typed;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
  } plan_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_item_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  cfg_t        shadow;
  int          row_pos;
  int          col_pos;
  bit          glyph_done;
  out_item_t   pending_pixels[$];
  plan_row_t   plan[$];
  int          fault_count = 0;
  bit          quiet = 1'b0;

  glyph_bitmap_pixel_expander uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fault_count++;
  endtask

  // expand one byte against the shadow setup; keep selects whether pixels are queued
  function automatic void expand_byte(in_item_t it, bit keep);
    out_item_t   drawn[$];
    out_item_t   p;
    logic [15:0] bx;
    logic [15:0] by;
    logic [1:0]  lvl;
    int          slots;
    int          w;
    int          h;
    bit          draw;
    bx    = shadow.pen_x + {{8{shadow.bearing_left[7]}}, shadow.bearing_left};
    by    = shadow.pen_y - {{8{shadow.bearing_top[7]}}, shadow.bearing_top};
    slots = shadow.two_bit_mode ? 4 : 8;
    w     = int'(shadow.glyph_width);
    h     = int'(shadow.glyph_height);
    if (it.glyph_start) begin
      row_pos    = 0;
      col_pos    = 0;
      glyph_done = 1'b0;
    end
    for (int i = 0; i < slots; i++) begin
      if (glyph_done || w == 0 || h == 0 || row_pos >= h) begin
        glyph_done = 1'b1;
        break;
      end
      if (shadow.two_bit_mode) begin
        lvl  = 2'(it.bitmap_byte >> ((3 - i) * 2));
        draw = (lvl != 2'd0) && (shadow.draw_black ? (lvl >= 2'd2) : (lvl < 2'd2));
      end else begin
        draw = it.bitmap_byte[7 - i];
      end
      if (draw) begin
        p.pixel_x      = bx + 16'(col_pos);
        p.pixel_y      = by + 16'(row_pos);
        p.pixel_color  = shadow.draw_black;
        p.last_of_byte = 1'b0;
        drawn.push_back(p);
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 255;
        if (row_pos == 0 || row_pos >= h) glyph_done = 1'b1;
      end else begin
        col_pos = (col_pos + 1) & 255;
      end
    end
    if (drawn.size() > 0) drawn[drawn.size() - 1].last_of_byte = 1'b1;
    if (keep) begin
      foreach (drawn[k]) pending_pixels.push_back(drawn[k]);
    end
  endfunction

  task automatic check_pixel(out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x)
      report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
    if (got.pixel_color !== want.pixel_color)
      report($sformatf("pixel_color got %b want %b", got.pixel_color, want.pixel_color));
    if (got.last_of_byte !== want.last_of_byte)
      report($sformatf("last_of_byte got %b want %b", got.last_of_byte, want.last_of_byte));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_pixel(out_item_o);
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 37);
  end

  task automatic send_byte(in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic feed(in_item_t it);
    expand_byte(it, 1'b1);
    send_byte(it);
  endtask

  task automatic wait_empty();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_empty();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    case (idx)
      RegCursorX:   shadow.pen_x        = val[15:0];
      RegCursorY:   shadow.pen_y        = val[15:0];
      RegBearLeft:  shadow.bearing_left = val[7:0];
      RegBearTop:   shadow.bearing_top  = val[7:0];
      RegWidth:     shadow.glyph_width  = val[7:0];
      RegHeight:    shadow.glyph_height = val[7:0];
      RegTwoBit:    shadow.two_bit_mode = val[0];
      RegDrawBlack: shadow.draw_black   = val[0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic plan_row_t blank_row();
    plan_row_t r;
    r.is_write = 1'b0;
    r.idx      = RegCursorX;
    r.val      = '0;
    r.it       = '0;
    r.n_typed  = 0;
    r.tx       = '0;
    r.ty       = '0;
    return r;
  endfunction

  function automatic plan_row_t wr(reg_idx_e idx, logic [31:0] val);
    plan_row_t r;
    r          = blank_row();
    r.is_write = 1'b1;
    r.idx      = idx;
    r.val      = val;
    return r;
  endfunction

  function automatic plan_row_t bt(logic [7:0] b, bit start, int n,
                                   logic signed [15:0] x, logic signed [15:0] y);
    plan_row_t r;
    r                = blank_row();
    r.it.bitmap_byte = b;
    r.it.glyph_start = start;
    r.n_typed        = n;
    r.tx             = x;
    r.ty             = y;
    return r;
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bearing();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bits();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic randomize_setup();
    int w;
    int h;
    case ($urandom_range(0, 19))
      0: begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        h = (w == 0) ? $urandom_range(0, 8) : 0;
      end
      1: begin
        w = 255;
        h = $urandom_range(1, 3);
      end
      2: begin
        w = $urandom_range(1, 3);
        h = 255;
      end
      default: begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
      end
    endcase
    write_reg(RegCursorX, {16'h0, pick_coord()});
    write_reg(RegCursorY, {16'h0, pick_coord()});
    write_reg(RegBearLeft, {24'h0, pick_bearing()});
    write_reg(RegBearTop, {24'h0, pick_bearing()});
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegTwoBit, $urandom_range(0, 1));
    write_reg(RegDrawBlack, $urandom_range(0, 1));
  endtask

  initial begin
    #(ClkPeriod * 400000);
    $display("tb_glyph_bitmap_pixel_expander failed");
    $finish;
  end

  initial begin
    in_item_t it;
    bit       dirty;
    bit       paused;
    int       sent;
    int       need;
    int       nbytes;
    out_item_t p;

    shadow              = '0;
    shadow.draw_black   = 1'b1;
    row_pos             = 0;
    col_pos             = 0;
    glyph_done          = 1'b0;
    dirty               = 1'b0;
    paused              = 1'b0;
    sent                = 0;

    plan.push_back(bt(8'hFF, 1'b1, 0, 16'sd0, 16'sd0));
    plan.push_back(wr(RegCursorX, 100));
    plan.push_back(wr(RegCursorY, 50));
    plan.push_back(wr(RegBearLeft, 3));
    plan.push_back(wr(RegBearTop, 10));
    plan.push_back(wr(RegWidth, 8));
    plan.push_back(wr(RegHeight, 2));
    plan.push_back(bt(8'h80, 1'b1, 1, 16'sd103, 16'sd40));
    plan.push_back(bt(8'hFF, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hFF, 1'b0, 0, 16'sd0, 16'sd0));
    plan.push_back(bt(8'h00, 1'b1, 0, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hA5, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegHeight, 0));
    plan.push_back(bt(8'hFF, 1'b1, 0, 16'sd0, 16'sd0));
    plan.push_back(wr(RegWidth, 3));
    plan.push_back(wr(RegHeight, 3));
    plan.push_back(bt(8'hFF, 1'b1, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hFF, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'h7E, 1'b0, 0, 16'sd0, 16'sd0));
    plan.push_back(wr(RegTwoBit, 1));
    plan.push_back(wr(RegWidth, 4));
    plan.push_back(wr(RegHeight, 2));
    plan.push_back(bt(8'h1B, 1'b1, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hE4, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegDrawBlack, 0));
    plan.push_back(bt(8'h1B, 1'b1, 1, 16'sd104, 16'sd40));
    plan.push_back(bt(8'h55, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegWidth, 8));
    plan.push_back(wr(RegHeight, 4));
    plan.push_back(wr(RegDrawBlack, 1));
    plan.push_back(bt(8'hFF, 1'b1, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegTwoBit, 0));
    plan.push_back(wr(RegWidth, 2));
    plan.push_back(bt(8'hFF, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hC3, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegCursorX, 32'h7FFF));
    plan.push_back(wr(RegCursorY, 32'h8000));
    plan.push_back(wr(RegBearLeft, 32'h7F));
    plan.push_back(wr(RegBearTop, 32'h7F));
    plan.push_back(wr(RegWidth, 8));
    plan.push_back(wr(RegHeight, 1));
    plan.push_back(bt(8'h80, 1'b1, 1, -16'sd32642, 16'sd32641));
    plan.push_back(bt(8'hFF, 1'b0, 0, 16'sd0, 16'sd0));
    plan.push_back(wr(RegCursorX, 32'h8000));
    plan.push_back(wr(RegCursorY, 32'h7FFF));
    plan.push_back(wr(RegBearLeft, 32'h80));
    plan.push_back(wr(RegBearTop, 32'h80));
    plan.push_back(bt(8'h01, 1'b1, 1, 16'sd32647, -16'sd32641));
    plan.push_back(wr(RegWidth, 255));
    plan.push_back(wr(RegHeight, 255));
    plan.push_back(bt(8'hFF, 1'b1, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'h00, 1'b0, 0, 16'sd0, 16'sd0));
    plan.push_back(bt(8'hAA, 1'b0, -1, 16'sd0, 16'sd0));
    plan.push_back(wr(RegTwoBit, 1));
    plan.push_back(wr(RegWidth, 1));
    plan.push_back(wr(RegDrawBlack, 0));
    plan.push_back(bt(8'h40, 1'b1, -1, 16'sd0, 16'sd0));
    plan.push_back(bt(8'h15, 1'b0, -1, 16'sd0, 16'sd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        if (dirty) settle();
        dirty = 1'b0;
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        if (plan[k].n_typed < 0) begin
          feed(plan[k].it);
        end else begin
          expand_byte(plan[k].it, 1'b0);
          if (plan[k].n_typed == 1) begin
            p.pixel_x      = plan[k].tx;
            p.pixel_y      = plan[k].ty;
            p.pixel_color  = shadow.draw_black;
            p.last_of_byte = 1'b1;
            pending_pixels.push_back(p);
          end
          send_byte(plan[k].it);
        end
        dirty = 1'b1;
      end
    end

    while (sent < RandomItems) begin
      if (dirty || $urandom_range(0, 1)) begin
        settle();
        randomize_setup();
        dirty = 1'b0;
      end
      need   = (int'(shadow.glyph_width) * int'(shadow.glyph_height)
                * (shadow.two_bit_mode ? 2 : 1) + 7) / 8;
      nbytes = need + $urandom_range(0, 2);
      if (nbytes > 24) nbytes = 24;
      if (nbytes < 1) nbytes = 1;
      for (int k = 0; k < nbytes; k++) begin
        quiet = (sent >= 120 && sent < 200);
        if (!paused && sent >= 250) begin
          paused = 1'b1;
          wait_empty();
        end
        it.bitmap_byte = pick_bits();
        if (k == 0) it.glyph_start = ($urandom_range(0, 7) != 0);
        else        it.glyph_start = ($urandom_range(0, 29) == 0);
        feed(it);
        sent++;
      end
      quiet = 1'b0;
      if ($urandom_range(0, 3) == 0) dirty = 1'b1;
    end

    wait_empty();
    repeat (SettleCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb_glyph_bitmap_pixel_expander passed");
    end else begin
      $display("tb_glyph_bitmap_pixel_expander failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
